/* rtl/prbt_pkg.sv */
// Shared types and constants of the pipe ring buffer table.
package prbt_pkg;

    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_WRITE  = 3'd1;
    localparam logic [2:0] KIND_READ   = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_QUERY  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EOF      = 3'd4;
    localparam logic [2:0] ST_RDCLOSED = 3'd5;
    localparam logic [2:0] ST_NOFREE   = 3'd6;

    localparam logic [7:0] FD_BASE = 8'd100;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] fd;
        logic [7:0] data_byte;
        logic [6:0] read_count;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic [7:0]  read_fd;
        logic [10:0] level;
        logic        last;
    } t_out_beat;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_WRITE,
        OP_READ,
        OP_CLOSE,
        OP_QUERY,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       fd_ok;
        logic [6:0] slot;
        logic       is_rd;
        logic [7:0] data_byte;
        logic [6:0] cnt;
        logic       cnt_zero;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RD_ADDR,
        S_RD_OUT
    } t_state;

endpackage

/* rtl/prbt_front.sv */
// Front end: accept input beats and decode them into commands.
module prbt_front #(
    parameter int NUM_PIPES = 8,
    parameter int MAX_READ  = 64
) (
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  prbt_pkg::t_in_beat   i_in_beat,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output prbt_pkg::t_cmd       o_cmd
);

    logic [8:0] fd_off;

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign fd_off     = {1'b0, i_in_beat.fd} - {1'b0, prbt_pkg::FD_BASE};

    always_comb begin
        o_cmd.slot      = fd_off[7:1];
        o_cmd.fd_ok     = !fd_off[8] && (fd_off[7:1] < 7'(NUM_PIPES));
        o_cmd.is_rd     = !fd_off[0];
        o_cmd.data_byte = i_in_beat.data_byte;
        o_cmd.cnt_zero  = (i_in_beat.read_count == 7'd0);
        o_cmd.cnt       = (i_in_beat.read_count > 7'(MAX_READ)) ? 7'(MAX_READ)
                                                                 : i_in_beat.read_count;
        unique case (i_in_beat.kind)
            prbt_pkg::KIND_CREATE: o_cmd.op = prbt_pkg::OP_CREATE;
            prbt_pkg::KIND_WRITE:  o_cmd.op = prbt_pkg::OP_WRITE;
            prbt_pkg::KIND_READ:   o_cmd.op = prbt_pkg::OP_READ;
            prbt_pkg::KIND_CLOSE:  o_cmd.op = prbt_pkg::OP_CLOSE;
            prbt_pkg::KIND_QUERY:  o_cmd.op = prbt_pkg::OP_QUERY;
            default:               o_cmd.op = prbt_pkg::OP_BAD;
        endcase
    end

endmodule

/* rtl/prbt_queue.sv */
// Short command queue between the front end and the back end.
module prbt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  prbt_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output prbt_pkg::t_cmd  o_cmd
);

    localparam int QD  = prbt_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

    prbt_pkg::t_cmd r_entry [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_entry[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QAW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QAW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_cmd;
        end
    end

endmodule

/* rtl/prbt_back.sv */
// Back end: pipe state table, byte store and result register.
module prbt_back #(
    parameter int NUM_PIPES = 8,
    parameter int BUF_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  prbt_pkg::t_cmd        i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output prbt_pkg::t_out_beat   o_out_beat
);

    localparam int SW  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PW  = $clog2(BUF_DEPTH);
    localparam int LW  = $clog2(BUF_DEPTH + 1);
    localparam int LXW = (LW > 7) ? LW : 7;
    localparam int MD  = 2 ** (SW + PW);

    prbt_pkg::t_state    r_state, n_state;
    prbt_pkg::t_cmd      r_cmd;
    prbt_pkg::t_out_beat r_out, c_res;
    logic                r_out_valid;

    logic [NUM_PIPES-1:0] r_used, r_rd_open, r_wr_open;
    logic [PW-1:0]        r_head [NUM_PIPES];
    logic [PW-1:0]        r_tail [NUM_PIPES];
    logic [LW-1:0]        r_fill [NUM_PIPES];
    logic [7:0]           r_store [MD];
    logic [7:0]           r_rdata;
    logic [6:0]           r_left;
    logic [LW-1:0]        r_lvl;

    logic          can_load, c_load;
    logic          c_create, c_write, c_rd_start, c_close, c_free, c_rd_issue;
    logic          c_new_rd, c_new_wr;
    logic [SW-1:0] sidx, free_idx;
    logic          free_found;
    logic [LW-1:0] cur_fill, n_lvl;
    logic [PW-1:0] cur_head, cur_tail;
    logic [6:0]    n_cnt;

    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_q_pop     = (r_state == prbt_pkg::S_IDLE) && i_q_valid;
    assign sidx        = r_cmd.slot[SW-1:0];
    assign cur_fill    = r_fill[sidx];
    assign cur_head    = r_head[sidx];
    assign cur_tail    = r_tail[sidx];
    assign n_cnt       = (LXW'(r_cmd.cnt) < LXW'(cur_fill)) ? r_cmd.cnt : 7'(cur_fill);
    assign n_lvl       = cur_fill - LW'(n_cnt);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    always_comb begin
        c_res      = '0;
        c_res.last = 1'b1;
        c_load     = 1'b0;
        c_create   = 1'b0;
        c_write    = 1'b0;
        c_rd_start = 1'b0;
        c_close    = 1'b0;
        c_free     = 1'b0;
        c_rd_issue = 1'b0;
        c_new_rd   = r_rd_open[sidx] && !r_cmd.is_rd;
        c_new_wr   = r_wr_open[sidx] && r_cmd.is_rd;
        unique case (r_state)
            prbt_pkg::S_IDLE: begin
            end
            prbt_pkg::S_EXEC: begin
                c_load = can_load;
                if (r_cmd.op == prbt_pkg::OP_CREATE) begin
                    if (free_found) begin
                        c_res.read_fd = prbt_pkg::FD_BASE + {7'(free_idx), 1'b0};
                        c_create      = can_load;
                    end else begin
                        c_res.status = prbt_pkg::ST_NOFREE;
                    end
                end else if (r_cmd.op == prbt_pkg::OP_BAD || !r_cmd.fd_ok || !r_used[sidx]) begin
                    c_res.status = prbt_pkg::ST_BAD;
                end else begin
                    c_res.level = 11'(cur_fill);
                    unique case (r_cmd.op)
                        prbt_pkg::OP_WRITE: begin
                            if (r_cmd.is_rd || !r_wr_open[sidx]) begin
                                c_res.status = prbt_pkg::ST_BAD;
                            end else if (!r_rd_open[sidx]) begin
                                c_res.status = prbt_pkg::ST_RDCLOSED;
                            end else if (cur_fill == LW'(BUF_DEPTH)) begin
                                c_res.status = prbt_pkg::ST_FULL;
                            end else begin
                                c_res.level = 11'(cur_fill + 1'b1);
                                c_write     = can_load;
                            end
                        end
                        prbt_pkg::OP_READ: begin
                            if (r_cmd.cnt_zero || !r_cmd.is_rd || !r_rd_open[sidx]) begin
                                c_res.status = prbt_pkg::ST_BAD;
                            end else if (cur_fill == '0) begin
                                c_res.status = r_wr_open[sidx] ? prbt_pkg::ST_EMPTY
                                                               : prbt_pkg::ST_EOF;
                            end else begin
                                c_rd_start = 1'b1;
                                c_load     = 1'b0;
                            end
                        end
                        prbt_pkg::OP_CLOSE: begin
                            c_close = can_load;
                            if (!c_new_rd && !c_new_wr) begin
                                c_free      = can_load;
                                c_res.level = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            prbt_pkg::S_RD_ADDR: begin
                c_rd_issue = 1'b1;
            end
            prbt_pkg::S_RD_OUT: begin
                c_load         = can_load;
                c_res.out_byte = r_rdata;
                c_res.level    = 11'(r_lvl);
                c_res.last     = (r_left == 7'd1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prbt_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = prbt_pkg::S_EXEC;
                end
            end
            prbt_pkg::S_EXEC: begin
                if (c_rd_start) begin
                    n_state = prbt_pkg::S_RD_ADDR;
                end else if (can_load) begin
                    n_state = prbt_pkg::S_IDLE;
                end
            end
            prbt_pkg::S_RD_ADDR: begin
                n_state = prbt_pkg::S_RD_OUT;
            end
            prbt_pkg::S_RD_OUT: begin
                if (can_load) begin
                    n_state = (r_left == 7'd1) ? prbt_pkg::S_IDLE : prbt_pkg::S_RD_ADDR;
                end
            end
            default: begin
                n_state = prbt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prbt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (c_load) begin
            r_out <= c_res;
        end
        if (c_rd_start) begin
            r_left <= n_cnt;
            r_lvl  <= n_lvl;
        end else if (r_state == prbt_pkg::S_RD_OUT && can_load) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_open <= '0;
            r_wr_open <= '0;
            for (int i = 0; i < NUM_PIPES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (c_create) begin
                r_used[free_idx]    <= 1'b1;
                r_rd_open[free_idx] <= 1'b1;
                r_wr_open[free_idx] <= 1'b1;
                r_head[free_idx]    <= '0;
                r_tail[free_idx]    <= '0;
                r_fill[free_idx]    <= '0;
            end
            if (c_write) begin
                r_tail[sidx] <= (cur_tail == PW'(BUF_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
                r_fill[sidx] <= cur_fill + 1'b1;
            end
            if (c_rd_start) begin
                r_fill[sidx] <= n_lvl;
            end
            if (c_rd_issue) begin
                r_head[sidx] <= (cur_head == PW'(BUF_DEPTH - 1)) ? '0 : cur_head + 1'b1;
            end
            if (c_close) begin
                r_rd_open[sidx] <= c_new_rd;
                r_wr_open[sidx] <= c_new_wr;
            end
            if (c_free) begin
                r_used[sidx] <= 1'b0;
                r_head[sidx] <= '0;
                r_tail[sidx] <= '0;
                r_fill[sidx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_write) begin
            r_store[{sidx, cur_tail}] <= r_cmd.data_byte;
        end
        if (c_rd_issue) begin
            r_rdata <= r_store[{sidx, cur_head}];
        end
    end

endmodule

/* rtl/pipe_ring_buffer_table.sv */
// Top level of the pipe ring buffer table.
//
// Input channel: i_in_valid / o_in_stall carry one command beat (create, write
// one byte, read, close one end, query level) on i_in_beat.
// Output channel: o_out_valid / i_out_stall carry result beats on o_out_beat.
// Every command gives one result beat, except a read that finds data: it gives
// one beat per delivered byte, the final one with last set.
// Commands pass a two-entry queue into a sequencer that owns the pipe table.
// A non-read command passes sequencer states IDLE and EXEC, and its result is
// registered. A read passes IDLE, EXEC, then RD_ADDR and RD_OUT per byte, due to
// the registered read of the single-port byte store.
// Reset clears the queue, the result valid flag and every slot (all pipes
// free); the byte store is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds its beat, the
// sequencer waits, the queue fills and o_in_stall rises.
module pipe_ring_buffer_table #(
    parameter int NUM_PIPES = 8,
    parameter int BUF_DEPTH = 1024,
    parameter int MAX_READ  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  prbt_pkg::t_in_beat    i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output prbt_pkg::t_out_beat   o_out_beat
);

    prbt_pkg::t_cmd push_cmd, head_cmd;
    logic           q_push, q_full, q_valid, q_pop;

    prbt_front #(
        .NUM_PIPES (NUM_PIPES),
        .MAX_READ  (MAX_READ)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_cmd      (push_cmd)
    );

    prbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    prbt_back #(
        .NUM_PIPES (NUM_PIPES),
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

/* tb/tb_pipe_ring_buffer_table.sv */
// Self-checking testbench for the pipe ring buffer table with its own predictor.
module tb_pipe_ring_buffer_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPIPE      = 8;
    localparam int DEPTH      = 1024;
    localparam int RD_MAX     = 64;
    localparam int RAND_ITEMS = 126;
    localparam int CALM_ITEMS = 30;

    typedef struct packed {
        prbt_pkg::t_in_beat  beat;
        logic                typed;
        prbt_pkg::t_out_beat want;
    } t_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    prbt_pkg::t_in_beat  in_beat;
    logic                out_valid;
    logic                out_stall;
    prbt_pkg::t_out_beat out_beat;

    logic [7:0] store_mem [NPIPE*DEPTH];
    int         head_idx [NPIPE];
    int         tail_idx [NPIPE];
    int         fill_cnt [NPIPE];
    bit         rd_open [NPIPE];
    bit         wr_open [NPIPE];
    bit         slot_busy [NPIPE];

    prbt_pkg::t_out_beat due_results[$];
    t_row                dir_rows [26];
    bit                  quiet;
    int                  errors;
    int                  n_cmds;
    int                  out_beats;

    pipe_ring_buffer_table #(
        .NUM_PIPES(NPIPE),
        .BUF_DEPTH(DEPTH),
        .MAX_READ (RD_MAX)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("tb_pipe_ring_buffer_table: done, errors");
        $finish;
    end

    function automatic int rd_end(input int s);
        return int'(prbt_pkg::FD_BASE) + 2 * s;
    endfunction

    function automatic int wr_end(input int s);
        return int'(prbt_pkg::FD_BASE) + 2 * s + 1;
    endfunction

    function automatic prbt_pkg::t_in_beat cmd(input logic [2:0] k, input int fd,
                                               input int d, input int c);
        prbt_pkg::t_in_beat b;
        b.kind       = k;
        b.fd         = 8'(fd);
        b.data_byte  = 8'(d);
        b.read_count = 7'(c);
        return b;
    endfunction

    function automatic prbt_pkg::t_out_beat res(input logic [2:0] st, input int rfd,
                                                input int lvl);
        prbt_pkg::t_out_beat r;
        r          = '0;
        r.status   = st;
        r.read_fd  = 8'(rfd);
        r.level    = 11'(lvl);
        r.last     = 1'b1;
        return r;
    endfunction

    task automatic pipe_table_step(input prbt_pkg::t_in_beat b);
        prbt_pkg::t_out_beat r;
        int        idx;
        int        s;
        int        fr;
        int        cnt;
        int        n;
        int        lvl;
        bit        is_rd;
        r      = '0;
        r.last = 1'b1;
        idx    = int'(b.fd) - int'(prbt_pkg::FD_BASE);
        s      = -1;
        fr     = -1;
        is_rd  = 1'b0;
        if (idx >= 0 && (idx >> 1) < NPIPE && slot_busy[idx >> 1]) begin
            s     = idx >> 1;
            is_rd = (idx % 2) == 0;
        end
        if (b.kind == prbt_pkg::KIND_CREATE) begin
            for (int i = NPIPE - 1; i >= 0; i--) begin
                if (!slot_busy[i]) fr = i;
            end
            if (fr < 0) begin
                r.status = prbt_pkg::ST_NOFREE;
            end else begin
                slot_busy[fr] = 1'b1;
                rd_open[fr]   = 1'b1;
                wr_open[fr]   = 1'b1;
                head_idx[fr]  = 0;
                tail_idx[fr]  = 0;
                fill_cnt[fr]  = 0;
                r.read_fd     = 8'(rd_end(fr));
            end
            due_results.push_back(r);
        end else if (b.kind > prbt_pkg::KIND_QUERY || s < 0) begin
            r.status = prbt_pkg::ST_BAD;
            due_results.push_back(r);
        end else if (b.kind == prbt_pkg::KIND_WRITE) begin
            if (is_rd || !wr_open[s]) begin
                r.status = prbt_pkg::ST_BAD;
            end else if (!rd_open[s]) begin
                r.status = prbt_pkg::ST_RDCLOSED;
            end else if (fill_cnt[s] >= DEPTH) begin
                r.status = prbt_pkg::ST_FULL;
            end else begin
                store_mem[s*DEPTH + tail_idx[s]] = b.data_byte;
                tail_idx[s] = (tail_idx[s] + 1) % DEPTH;
                fill_cnt[s]++;
            end
            r.level = 11'(fill_cnt[s]);
            due_results.push_back(r);
        end else if (b.kind == prbt_pkg::KIND_READ) begin
            if (b.read_count == 0 || !is_rd || !rd_open[s]) begin
                r.status = prbt_pkg::ST_BAD;
                r.level  = 11'(fill_cnt[s]);
                due_results.push_back(r);
            end else if (fill_cnt[s] == 0) begin
                r.status = wr_open[s] ? prbt_pkg::ST_EMPTY : prbt_pkg::ST_EOF;
                due_results.push_back(r);
            end else begin
                cnt     = (b.read_count > RD_MAX) ? RD_MAX : int'(b.read_count);
                n       = (cnt < fill_cnt[s]) ? cnt : fill_cnt[s];
                lvl     = fill_cnt[s] - n;
                r.level = 11'(lvl);
                for (int k = 0; k < n; k++) begin
                    r.out_byte  = store_mem[s*DEPTH + head_idx[s]];
                    head_idx[s] = (head_idx[s] + 1) % DEPTH;
                    r.last      = (k == n - 1);
                    due_results.push_back(r);
                end
                fill_cnt[s] = lvl;
            end
        end else if (b.kind == prbt_pkg::KIND_CLOSE) begin
            if (is_rd) rd_open[s] = 1'b0;
            else wr_open[s] = 1'b0;
            if (!rd_open[s] && !wr_open[s]) begin
                slot_busy[s] = 1'b0;
                head_idx[s]  = 0;
                tail_idx[s]  = 0;
                fill_cnt[s]  = 0;
            end
            r.level = 11'(fill_cnt[s]);
            due_results.push_back(r);
        end else begin
            r.level = 11'(fill_cnt[s]);
            due_results.push_back(r);
        end
    endtask

    function automatic prbt_pkg::t_in_beat random_cmd();
        prbt_pkg::t_in_beat b;
        int       live[$];
        int       pick;
        int       s;
        foreach (slot_busy[i]) begin
            if (slot_busy[i]) live.push_back(i);
        end
        pick         = $urandom_range(0, 99);
        b.kind       = prbt_pkg::KIND_CREATE;
        b.fd         = 8'($urandom_range(0, 255));
        b.data_byte  = 8'($urandom_range(0, 255));
        b.read_count = 7'($urandom_range(0, 127));
        if (live.size() > 0 && pick >= 8) begin
            s = live[$urandom_range(0, live.size() - 1)];
            if (pick < 48) begin
                b.kind = prbt_pkg::KIND_WRITE;
                b.fd   = 8'(wr_end(s));
            end else if (pick < 73) begin
                b.kind = prbt_pkg::KIND_READ;
                b.fd   = 8'(rd_end(s));
                if ($urandom_range(0, 4) != 0) b.read_count = 7'($urandom_range(1, 8));
            end else if (pick < 80) begin
                b.kind = prbt_pkg::KIND_CLOSE;
                b.fd   = 8'($urandom_range(0, 1) ? rd_end(s) : wr_end(s));
            end else if (pick < 90) begin
                b.kind = prbt_pkg::KIND_QUERY;
                b.fd   = 8'($urandom_range(0, 1) ? rd_end(s) : wr_end(s));
            end else begin
                b.kind = 3'($urandom_range(0, 7));
            end
        end
        return b;
    endfunction

    task automatic send_cmd(input prbt_pkg::t_in_beat b, input bit typed,
                            input prbt_pkg::t_out_beat want);
        int mark;
        int gap;
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        mark = due_results.size();
        pipe_table_step(b);
        if (typed) begin
            while (due_results.size() > mark) void'(due_results.pop_back());
            due_results.push_back(want);
        end
        n_cmds++;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_beat(input prbt_pkg::t_out_beat got);
        prbt_pkg::t_out_beat want;
        out_beats++;
        if (due_results.size() == 0) begin
            errors++;
            $error("unexpected result beat %h", got);
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status) begin
            errors++;
            $error("status: expected %0d, got %0d", want.status, got.status);
        end
        if (got.out_byte !== want.out_byte) begin
            errors++;
            $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
        end
        if (got.read_fd !== want.read_fd) begin
            errors++;
            $error("read_fd: expected %0d, got %0d", want.read_fd, got.read_fd);
        end
        if (got.level !== want.level) begin
            errors++;
            $error("level: expected %0d, got %0d", want.level, got.level);
        end
        if (got.last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, got.last);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) check_beat(out_beat);
    end

    initial begin : stall_gen
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (!quiet) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : main
        quiet     = 1'b0;
        errors    = 0;
        n_cmds    = 0;
        out_beats = 0;
        in_valid  <= 1'b0;
        in_beat   <= '0;
        rst_n     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        dir_rows = '{
            '{cmd(prbt_pkg::KIND_QUERY, rd_end(0), 0, 1), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)},
            '{cmd(prbt_pkg::KIND_WRITE, 99, 0, 1), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)},
            '{cmd(3'd5, rd_end(0), 0, 1), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)},
            '{cmd(3'd7, 255, 255, 127), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)},
            '{cmd(prbt_pkg::KIND_CREATE, 0, 0, 0), 1'b1, res(prbt_pkg::ST_OK, rd_end(0), 0)},
            '{cmd(prbt_pkg::KIND_CREATE, 0, 0, 0), 1'b1, res(prbt_pkg::ST_OK, rd_end(1), 0)},
            '{cmd(prbt_pkg::KIND_WRITE, wr_end(0), 0, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 1)},
            '{cmd(prbt_pkg::KIND_WRITE, wr_end(0), 255, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 2)},
            '{cmd(prbt_pkg::KIND_WRITE, rd_end(0), 17, 0), 1'b1, res(prbt_pkg::ST_BAD, 0, 2)},
            '{cmd(prbt_pkg::KIND_READ, wr_end(0), 0, 5), 1'b1, res(prbt_pkg::ST_BAD, 0, 2)},
            '{cmd(prbt_pkg::KIND_READ, rd_end(0), 0, 0), 1'b1, res(prbt_pkg::ST_BAD, 0, 2)},
            '{cmd(prbt_pkg::KIND_READ, rd_end(0), 0, 127), 1'b0, '0},
            '{cmd(prbt_pkg::KIND_READ, rd_end(0), 0, 1), 1'b1, res(prbt_pkg::ST_EMPTY, 0, 0)},
            '{cmd(prbt_pkg::KIND_QUERY, rd_end(8), 0, 1), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)},
            '{cmd(prbt_pkg::KIND_CLOSE, rd_end(0), 0, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 0)},
            '{cmd(prbt_pkg::KIND_WRITE, wr_end(0), 33, 0), 1'b1,
              res(prbt_pkg::ST_RDCLOSED, 0, 0)},
            '{cmd(prbt_pkg::KIND_READ, rd_end(0), 0, 1), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)},
            '{cmd(prbt_pkg::KIND_CLOSE, rd_end(0), 0, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 0)},
            '{cmd(prbt_pkg::KIND_WRITE, wr_end(1), 165, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 1)},
            '{cmd(prbt_pkg::KIND_WRITE, wr_end(1), 90, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 2)},
            '{cmd(prbt_pkg::KIND_CLOSE, wr_end(1), 0, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 2)},
            '{cmd(prbt_pkg::KIND_WRITE, wr_end(1), 1, 0), 1'b1, res(prbt_pkg::ST_BAD, 0, 2)},
            '{cmd(prbt_pkg::KIND_READ, rd_end(1), 0, 64), 1'b0, '0},
            '{cmd(prbt_pkg::KIND_READ, rd_end(1), 0, 1), 1'b1, res(prbt_pkg::ST_EOF, 0, 0)},
            '{cmd(prbt_pkg::KIND_CLOSE, wr_end(0), 0, 0), 1'b1, res(prbt_pkg::ST_OK, 0, 0)},
            '{cmd(prbt_pkg::KIND_QUERY, wr_end(0), 0, 0), 1'b1, res(prbt_pkg::ST_BAD, 0, 0)}
        };
        foreach (dir_rows[i]) send_cmd(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        for (int i = 0; i < NPIPE; i++) begin
            if (!slot_busy[i]) send_cmd(cmd(prbt_pkg::KIND_CREATE, 0, 0, 0), 1'b0, '0);
        end
        send_cmd(cmd(prbt_pkg::KIND_CREATE, 0, 0, 0), 1'b1, res(prbt_pkg::ST_NOFREE, 0, 0));

        for (int i = 0; i < RAND_ITEMS; i++) begin
            quiet = (i >= RAND_ITEMS - CALM_ITEMS);
            send_cmd(random_cmd(), 1'b0, '0);
        end
        if (in_valid) in_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("summary: %0d commands in, %0d result beats checked", n_cmds, out_beats);
        $display("summary: corner cases, table exhaustion and a random mix over %0d pipes",
                 NPIPE);
        if (errors == 0) begin
            $display("tb_pipe_ring_buffer_table: done, clean");
        end else begin
            $display("tb_pipe_ring_buffer_table: done, errors");
        end
        $finish;
    end

endmodule
